>>> sv/tbf_pkg.sv
// shared types, constants and set-algebra helpers for the belief fusion block
// no dependencies; imported by every other file of the block
package tbf_pkg;

	localparam int NSETS  = 7;
	localparam int IDX_W  = 3;
	localparam int MASS_W = 17;
	localparam int FRAC_W = 16;
	localparam int TOL_W  = 8;
	localparam int STAT_W = 2;
	// 49 products of two 17-bit masses stay below 2^40
	localparam int ACC_W  = 40;
	// dividend (acc << 16) + total / 2 and divisor shifted up by a full quotient width
	localparam int DIV_W  = ACC_W + MASS_W + 1;
	localparam int CNT_W  = 5;

	typedef logic [MASS_W-1:0] mass_t;
	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [ACC_W-1:0]  acc_t;
	typedef logic [DIV_W-1:0]  dword_t;
	typedef logic [TOL_W-1:0]  tol_t;
	typedef logic [STAT_W-1:0] status_t;

	localparam mass_t   MASS_ONE      = mass_t'(1 << FRAC_W);
	localparam idx_t    LAST_IDX      = idx_t'(NSETS - 1);
	localparam tol_t    TOL_RESET     = tol_t'(1);

	localparam status_t ST_SUM_ONE    = status_t'(0);
	localparam status_t ST_NORMALIZED = status_t'(1);
	localparam status_t ST_OVER_ONE   = status_t'(2);
	localparam status_t ST_CONFLICT   = status_t'(3);

	// command word from the sequencer to the multiply-accumulate unit
	typedef struct packed {
		logic clear;
		logic issue;
		logic k_valid;
		idx_t k;
		idx_t rd_idx;
	} mac_cmd_t;

	// subset membership bits {c,b,a} for the set order a, b, c, ab, ac, bc, abc
	function automatic logic [2:0] set_bits(idx_t i);
		logic [2:0] r;
		case (i)
			3'd0:    r = 3'b001;
			3'd1:    r = 3'b010;
			3'd2:    r = 3'b100;
			3'd3:    r = 3'b011;
			3'd4:    r = 3'b101;
			3'd5:    r = 3'b110;
			default: r = 3'b111;
		endcase
		return r;
	endfunction

	// intersection of two sets: {valid, index}; empty set is conflict
	function automatic logic [IDX_W:0] meet(idx_t i, idx_t j);
		logic [2:0]     b;
		logic [IDX_W:0] r;
		b = set_bits(i) & set_bits(j);
		case (b)
			3'b001:  r = {1'b1, 3'd0};
			3'b010:  r = {1'b1, 3'd1};
			3'b100:  r = {1'b1, 3'd2};
			3'b011:  r = {1'b1, 3'd3};
			3'b101:  r = {1'b1, 3'd4};
			3'b110:  r = {1'b1, 3'd5};
			3'b111:  r = {1'b1, 3'd6};
			default: r = {1'b0, 3'd0};
		endcase
		return r;
	endfunction

endpackage

>>> sv/tbf_ifs.sv
// valid/ready channel interfaces: input word, result word, tolerance write
// depends on tbf_pkg
interface tbf_in_if;
	import tbf_pkg::*;
	logic  valid;
	logic  ready;
	logic  op;
	mass_t in_mass_a;
	mass_t in_mass_b;
	mass_t in_mass_c;
	mass_t in_mass_ab;
	mass_t in_mass_ac;
	mass_t in_mass_bc;
	mass_t in_mass_abc;

	modport source (output valid, op, in_mass_a, in_mass_b, in_mass_c, in_mass_ab,
		in_mass_ac, in_mass_bc, in_mass_abc, input ready);
	modport sink (input valid, op, in_mass_a, in_mass_b, in_mass_c, in_mass_ab,
		in_mass_ac, in_mass_bc, in_mass_abc, output ready);
endinterface

interface tbf_out_if;
	import tbf_pkg::*;
	logic    valid;
	logic    ready;
	mass_t   out_mass_a;
	mass_t   out_mass_b;
	mass_t   out_mass_c;
	mass_t   out_mass_ab;
	mass_t   out_mass_ac;
	mass_t   out_mass_bc;
	mass_t   out_mass_abc;
	status_t status;

	modport source (output valid, out_mass_a, out_mass_b, out_mass_c, out_mass_ab,
		out_mass_ac, out_mass_bc, out_mass_abc, status, input ready);
	modport sink (input valid, out_mass_a, out_mass_b, out_mass_c, out_mass_ab,
		out_mass_ac, out_mass_bc, out_mass_abc, status, output ready);
endinterface

interface tbf_cfg_if;
	import tbf_pkg::*;
	logic valid;
	logic ready;
	tol_t data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

>>> sv/tbf_div.sv
// iterative restoring divider: one quotient bit per cycle, saturates at one
// depends on tbf_pkg
module tbf_div (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  tbf_pkg::dword_t num,
	input  tbf_pkg::acc_t den,
	output logic          done,
	output tbf_pkg::mass_t quo
);
	import tbf_pkg::*;

	typedef enum logic [1:0] {D_IDLE, D_CHECK, D_STEP} dstate_t;

	dstate_t            dstate_q;
	dword_t             rem_q;
	dword_t             dsh_q;
	mass_t              q_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               done_q;
	mass_t              quo_q;

	logic  ge;
	mass_t q_nxt;

	assign ge    = (rem_q >= dsh_q);
	assign q_nxt = {q_q[MASS_W-2:0], ge};
	assign done  = done_q;
	assign quo   = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dstate_q <= D_IDLE;
			rem_q    <= '0;
			dsh_q    <= '0;
			q_q      <= '0;
			cnt_q    <= '0;
			done_q   <= 1'b0;
			quo_q    <= '0;
		end else begin
			done_q <= 1'b0;
			case (dstate_q)
				D_IDLE: begin
					if (start) begin
						rem_q    <= num;
						dsh_q    <= dword_t'(den) << MASS_W;
						q_q      <= '0;
						dstate_q <= D_CHECK;
					end
				end
				D_CHECK: begin
					// quotient of 2^17 or more saturates
					if (ge) begin
						quo_q    <= MASS_ONE;
						done_q   <= 1'b1;
						dstate_q <= D_IDLE;
					end else begin
						dsh_q    <= dsh_q >> 1;
						cnt_q    <= CNT_W'(MASS_W - 1);
						dstate_q <= D_STEP;
					end
				end
				D_STEP: begin
					if (ge) begin
						rem_q <= rem_q - dsh_q;
					end
					q_q   <= q_nxt;
					dsh_q <= dsh_q >> 1;
					if (cnt_q == '0) begin
						quo_q    <= (q_nxt > MASS_ONE) ? MASS_ONE : q_nxt;
						done_q   <= 1'b1;
						dstate_q <= D_IDLE;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				default: dstate_q <= D_IDLE;
			endcase
		end
	end

endmodule

>>> sv/tbf_mac.sv
// shared multiplier with registered product and seven set accumulators
// depends on tbf_pkg
module tbf_mac (
	input  logic              clk,
	input  logic              arst_n,
	input  tbf_pkg::mac_cmd_t cmd,
	input  tbf_pkg::mass_t    a,
	input  tbf_pkg::mass_t    b,
	output tbf_pkg::acc_t     acc_rd,
	output tbf_pkg::acc_t     total
);
	import tbf_pkg::*;

	logic [2*MASS_W-1:0] prod_s1;
	idx_t                k_s1;
	logic                kv_s1;
	acc_t                acc_q [NSETS];
	acc_t                total_q;
	idx_t                rd_addr;

	// single read port: accumulate address while a product is pending
	assign rd_addr = kv_s1 ? k_s1 : cmd.rd_idx;
	assign acc_rd  = acc_q[rd_addr];
	assign total   = total_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kv_s1 <= 1'b0;
		end else begin
			kv_s1 <= cmd.issue && cmd.k_valid;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= a * b;
		k_s1    <= cmd.k;
	end

	always_ff @(posedge clk) begin
		if (cmd.clear) begin
			for (int n = 0; n < NSETS; n++) begin
				acc_q[n] <= '0;
			end
			total_q <= '0;
		end else if (kv_s1) begin
			acc_q[k_s1] <= acc_rd + ACC_W'(prod_s1);
			total_q     <= total_q + ACC_W'(prod_s1);
		end
	end

endmodule

>>> sv/three_hypothesis_belief_fusion.sv
// one word at a time: a load word passes its 7 masses through the shared multiplier, a combine
// word all 49 products, and when the sum is renormalized the bit-serial divider then divides
// each of the 7 masses in turn; the next word is taken only once all 7 masses are written back
// a new word is taken while the previous result still waits on the output register
// reset (asynchronous, active low): whole-frame mass one, others zero, tolerance one lsb
// depends on tbf_pkg, tbf_ifs, tbf_mac, tbf_div
module three_hypothesis_belief_fusion (
	input  logic clk,
	input  logic arst_n,
	tbf_in_if.sink    item,
	tbf_out_if.source result,
	tbf_cfg_if.sink   cfg
);
	import tbf_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MAC,
		S_DRAIN,
		S_CLASS,
		S_WAIT_OUT,
		S_NEXT,
		S_DIV
	} state_t;

	localparam acc_t ONE32   = acc_t'(64'd1 << (2 * FRAC_W));
	localparam acc_t RND_BIT = acc_t'(1 << (FRAC_W - 1));

	state_t  state_q;
	logic    op_q;
	mass_t   obs_q      [NSETS];
	mass_t   cell_q     [NSETS];
	mass_t   out_mass_q [NSETS];
	status_t out_status_q;
	logic    out_valid_q;
	status_t status_q;
	tol_t    tol_q;
	idx_t    i_q;
	idx_t    j_q;
	idx_t    idx_q;

	// shared datapath hookup
	mac_cmd_t       cmd;
	mass_t          mac_a;
	mass_t          mac_b;
	acc_t           acc_rd;
	acc_t           total;
	logic [IDX_W:0] meet_ij;
	idx_t           cell_addr;
	mass_t          cell_rd;
	logic           div_start;
	logic           div_done;
	mass_t          div_quo;
	dword_t         div_num;

	// write-back of one mass
	logic                     wb_en;
	mass_t                    wb_val;
	acc_t                     rnd_sum;
	logic [ACC_W-FRAC_W-1:0]  rnd;
	mass_t                    pass_val;
	acc_t                     tol_sh;

	logic accept;
	logic result_take;

	assign accept      = item.valid && item.ready;
	assign result_take = result.valid && result.ready;
	assign item.ready  = (state_q == S_IDLE);
	assign cfg.ready   = 1'b1;

	// cell array has one read port: row index while multiplying, write-back index after
	assign cell_addr = (state_q == S_MAC) ? i_q : idx_q;
	assign cell_rd   = cell_q[cell_addr];
	assign meet_ij   = meet(i_q, j_q);

	// load pushes each mass through the multiplier as m * 1.0, landing in Q.32 like a product
	assign mac_a = op_q ? cell_rd : MASS_ONE;
	assign mac_b = obs_q[j_q];

	always_comb begin
		cmd.clear   = accept;
		cmd.issue   = (state_q == S_MAC);
		cmd.k_valid = op_q ? meet_ij[IDX_W] : 1'b1;
		cmd.k       = op_q ? meet_ij[IDX_W-1:0] : j_q;
		cmd.rd_idx  = idx_q;
	end

	tbf_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.a      (mac_a),
		.b      (mac_b),
		.acc_rd (acc_rd),
		.total  (total)
	);

	// dividend is m * 2^16 + total / 2, rounded quotient against total
	assign div_num   = dword_t'({acc_rd, {FRAC_W{1'b0}}}) + dword_t'(total >> 1);
	assign div_start = (state_q == S_NEXT) && (status_q == ST_NORMALIZED);

	tbf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (total),
		.done   (div_done),
		.quo    (div_quo)
	);

	// unnormalized path: combine rounds Q.32 to Q1.16 and saturates, load stores as given
	assign rnd_sum  = acc_rd + RND_BIT;
	assign rnd      = rnd_sum[ACC_W-1:FRAC_W];
	assign pass_val = op_q ? ((rnd > (ACC_W-FRAC_W)'(MASS_ONE)) ? MASS_ONE : mass_t'(rnd))
		: acc_rd[FRAC_W+MASS_W-1:FRAC_W];

	// tolerance band around one, scaled to Q.32
	assign tol_sh = acc_t'(tol_q) << FRAC_W;

	always_comb begin
		wb_en  = 1'b0;
		wb_val = pass_val;
		if (state_q == S_NEXT) begin
			case (status_q)
				ST_NORMALIZED: wb_en = 1'b0;
				ST_CONFLICT: begin
					wb_en  = 1'b1;
					wb_val = cell_rd;
				end
				default: wb_en = 1'b1;
			endcase
		end else if (state_q == S_DIV && div_done) begin
			wb_en  = 1'b1;
			wb_val = div_quo;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			op_q         <= 1'b0;
			status_q     <= ST_SUM_ONE;
			out_status_q <= ST_SUM_ONE;
			out_valid_q  <= 1'b0;
			tol_q        <= TOL_RESET;
			i_q          <= '0;
			j_q          <= '0;
			idx_q        <= '0;
			for (int n = 0; n < NSETS; n++) begin
				obs_q[n]      <= '0;
				cell_q[n]     <= '0;
				out_mass_q[n] <= '0;
			end
			cell_q[NSETS-1] <= MASS_ONE;
		end else begin
			if (cfg.valid && cfg.ready) begin
				tol_q <= cfg.data;
			end
			if (result_take) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q     <= item.op;
						obs_q[0] <= item.in_mass_a;
						obs_q[1] <= item.in_mass_b;
						obs_q[2] <= item.in_mass_c;
						obs_q[3] <= item.in_mass_ab;
						obs_q[4] <= item.in_mass_ac;
						obs_q[5] <= item.in_mass_bc;
						obs_q[6] <= item.in_mass_abc;
						i_q      <= '0;
						j_q      <= '0;
						state_q  <= S_MAC;
					end
				end
				// one product per cycle: cell row i against observation column j
				S_MAC: begin
					if (j_q == LAST_IDX) begin
						j_q <= '0;
						if (!op_q || i_q == LAST_IDX) begin
							state_q <= S_DRAIN;
						end else begin
							i_q <= i_q + 1'b1;
						end
					end else begin
						j_q <= j_q + 1'b1;
					end
				end
				// last product lands in its accumulator
				S_DRAIN: begin
					state_q <= S_CLASS;
				end
				S_CLASS: begin
					if (total == '0) begin
						status_q <= ST_CONFLICT;
					end else if (total + tol_sh < ONE32) begin
						status_q <= ST_NORMALIZED;
					end else if (total <= ONE32 + tol_sh) begin
						status_q <= ST_SUM_ONE;
					end else begin
						status_q <= ST_OVER_ONE;
					end
					idx_q   <= '0;
					state_q <= S_WAIT_OUT;
				end
				// result registers are rewritten in place, so the previous word must be gone
				S_WAIT_OUT: begin
					if (!out_valid_q) begin
						state_q <= S_NEXT;
					end
				end
				S_NEXT: begin
					if (status_q == ST_NORMALIZED) begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_NEXT;
					end
				end
				default: state_q <= S_IDLE;
			endcase

			if (wb_en) begin
				out_mass_q[idx_q] <= wb_val;
				// total conflict or empty load leaves the cell as it was
				if (status_q != ST_CONFLICT) begin
					cell_q[idx_q] <= wb_val;
				end
				if (idx_q == LAST_IDX) begin
					out_status_q <= status_q;
					out_valid_q  <= 1'b1;
					state_q      <= S_IDLE;
				end else begin
					idx_q <= idx_q + 1'b1;
				end
			end
		end
	end

	assign result.valid        = out_valid_q;
	assign result.out_mass_a   = out_mass_q[0];
	assign result.out_mass_b   = out_mass_q[1];
	assign result.out_mass_c   = out_mass_q[2];
	assign result.out_mass_ab  = out_mass_q[3];
	assign result.out_mass_ac  = out_mass_q[4];
	assign result.out_mass_bc  = out_mass_q[5];
	assign result.out_mass_abc = out_mass_q[6];
	assign result.status       = out_status_q;

endmodule
